// ===== rtl/tablet_packet_event_decoder_unit_assert.svh =====
// assertion macros for the tablet packet event decoder
// used by the top level; needs nothing else
`ifndef TABLET_PACKET_EVENT_DECODER_UNIT_ASSERT_SVH
`define TABLET_PACKET_EVENT_DECODER_UNIT_ASSERT_SVH

// clocked assertion, disabled while the active-low reset is low
`define TPED_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same, on the usual clock and reset of this block
`define TPED_ASSERT(label, prop, msg) \
    `TPED_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

// ===== rtl/tped_pkg.sv =====
// constants and codes for the tablet packet event decoder
// no dependencies
package tped_pkg;

    // packet layout
    localparam int PACKET_BYTES  = 7;
    localparam int IDX_W         = 3;
    localparam int PROX_BIT_POS  = 6;
    localparam int XSIGN_BIT_POS = 4;
    localparam int YSIGN_BIT_POS = 3;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PACKET_BYTES - 1);

    // field widths
    localparam int COORD_W = 15;
    localparam int RAW_W   = 14;
    localparam int PRES_W  = 10;
    localparam int BTN_W   = 3;
    localparam int NBTN    = 4;
    localparam int NEV     = 6;  // proximity, motion, four buttons
    localparam int TDATA_W = 48;
    localparam int TUSER_W = 2;
    localparam int CFG_W   = 14;

    // configuration register indexes
    localparam logic [1:0] CFG_ABS_MODE = 2'd0;
    localparam logic [1:0] CFG_MAX_Y    = 2'd1;
    localparam logic [1:0] CFG_CORE_PTR = 2'd2;

    // event kinds
    localparam logic [1:0] EV_PROX_IN  = 2'd0;
    localparam logic [1:0] EV_PROX_OUT = 2'd1;
    localparam logic [1:0] EV_MOTION   = 2'd2;
    localparam logic [1:0] EV_BUTTON   = 2'd3;

    // pending event slots
    localparam logic [2:0] SLOT_PROX   = 3'd0;
    localparam logic [2:0] SLOT_MOTION = 3'd1;
    localparam logic [2:0] SLOT_BTN1   = 3'd2;
    localparam logic [2:0] SLOT_BTN2   = 3'd3;
    localparam logic [2:0] SLOT_BTN3   = 3'd4;
    localparam logic [2:0] SLOT_BTN4   = 3'd5;

    typedef logic signed [COORD_W-1:0] t_coord;

endpackage

// ===== rtl/tablet_packet_event_decoder_unit.sv =====
// Pen tablet serial byte stream to pointer events.
//
// Slave stream: one received byte per request on i_s_axis_tdata. A byte with
// bit 7 set starts a packet while waiting; the next six bytes complete it.
// Master stream: one event per request; tuser holds the event kind, tlast marks
// the final event that a packet causes. A packet may cause no event at all.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_idx
// (0 absolute mode, 1 y extent, 2 core pointer); write only while idle.
//
// Throughput: one byte accepted per cycle, a held-off final byte apart. The
// final byte of a packet is decoded in the cycle it is accepted; its events
// (up to six) sit in a pending register and leave one per cycle, while the
// receiver takes them, through the output register after the pending one.
// The pending register is the limit: while it still holds events, a final
// byte is held off (tready low); all other bytes are taken every cycle.
// A stalled receiver holds the output register and its payload.
// Reset (synchronous, active low) returns to waiting for a header, clears the
// previous pen state, pending events and output valid, and loads register
// defaults (absolute mode on, y extent 16383, core pointer off).

`include "tablet_packet_event_decoder_unit_assert.svh"

module tablet_packet_event_decoder_unit
    import tped_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // slave stream
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [7:0]         i_s_axis_tdata,  // [7:0] rx_byte
    // master stream
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // [14:0] pos_x, [29:15] pos_y, [39:30] pressure, [42:40] button_number,
    // [43] button_down, [44] abs_flag, [47:45] zero
    output logic [TDATA_W-1:0] o_m_axis_tdata,
    output logic [TUSER_W-1:0] o_m_axis_tuser,  // [1:0] event_kind
    output logic               o_m_axis_tlast,  // last_event
    // configuration
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_wdata
);

    // configuration
    logic               r_abs_mode;
    logic [RAW_W-1:0]   r_max_y;
    logic               r_core_ptr;

    // byte capture
    logic [IDX_W-1:0]   r_idx;
    logic [7:0]         r_store [PACKET_BYTES-1];

    // previous pen state
    t_coord             r_prev_x;
    t_coord             r_prev_y;
    logic [PRES_W-1:0]  r_prev_z;
    logic [NBTN-1:0]    r_prev_btn;
    logic               r_prev_prox;

    // pending events of the last packet
    logic [NEV-1:0]     r_pmask;
    logic               r_p_prox;
    logic               r_p_abs;
    t_coord             r_p_x;
    t_coord             r_p_y;
    logic [PRES_W-1:0]  r_p_z;
    logic [NBTN-1:0]    r_p_btn;

    // output register
    logic               r_out_valid;
    logic [1:0]         r_out_kind;
    t_coord             r_out_x;
    t_coord             r_out_y;
    logic [PRES_W-1:0]  r_out_z;
    logic [BTN_W-1:0]   r_out_bnum;
    logic               r_out_bdown;
    logic               r_out_abs;
    logic               r_out_last;

    logic               s_fire;
    logic               pkt_done;
    logic [7:0]         b_in;
    logic [7:0]         hdr;
    logic [RAW_W-1:0]   x_raw;
    logic [RAW_W-1:0]   y_raw;
    t_coord             dec_x;
    t_coord             dec_y;
    logic [PRES_W-1:0]  dec_z;
    logic [NBTN-1:0]    dec_btn;
    logic               dec_prox;
    logic               motion;
    logic [NEV-1:0]     n_mask;

    logic               out_load;
    logic               pop;
    logic [2:0]         sel;
    logic [NEV-1:0]     pick;
    logic [NEV-1:0]     rest;
    logic [1:0]         n_kind;
    logic [BTN_W-1:0]   n_bnum;
    logic               n_bdown;
    logic               n_abs;

    // a final byte waits while the pending register still holds events
    assign o_s_axis_tready = !((r_idx == LAST_IDX) && (r_pmask != '0));
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign pkt_done        = s_fire && (r_idx == LAST_IDX);
    assign b_in            = i_s_axis_tdata;

    // packet decode, final byte comes straight from the input
    always_comb begin
        hdr      = r_store[0];
        x_raw    = {r_store[2][6:0], r_store[1][6:0]};
        y_raw    = {r_store[4][6:0], r_store[3][6:0]};
        dec_z    = {r_store[5], b_in[0], b_in[4]};
        dec_btn  = {b_in[1], hdr[2:0]};
        dec_prox = !hdr[PROX_BIT_POS];
        if (r_abs_mode) begin
            dec_x = $signed({1'b0, x_raw});
            dec_y = $signed({1'b0, r_max_y}) - $signed({1'b0, y_raw});
        end else begin
            dec_x = hdr[XSIGN_BIT_POS] ? $signed({1'b0, x_raw}) : -$signed({1'b0, x_raw});
            dec_y = hdr[YSIGN_BIT_POS] ? $signed({1'b0, y_raw}) : -$signed({1'b0, y_raw});
        end
        if (r_abs_mode) begin
            motion = (r_prev_x != dec_x) || (r_prev_y != dec_y) || (r_prev_z != dec_z);
        end else begin
            motion = ((x_raw != '0) || (y_raw != '0)) && r_prev_prox;
        end
        if (dec_prox) begin
            n_mask = {dec_btn ^ r_prev_btn, motion, !r_prev_prox && !r_core_ptr};
        end else begin
            n_mask = {{(NEV-1){1'b0}}, !r_core_ptr && r_prev_prox};
        end
    end

    // event issue: lowest pending slot first
    assign out_load = !r_out_valid || i_m_axis_tready;
    assign pop      = out_load && (r_pmask != '0);
    assign pick     = r_pmask & (~r_pmask + NEV'(1));
    assign rest     = r_pmask & ~pick;

    always_comb begin
        priority if (r_pmask[0]) sel = SLOT_PROX;
        else if (r_pmask[1])     sel = SLOT_MOTION;
        else if (r_pmask[2])     sel = SLOT_BTN1;
        else if (r_pmask[3])     sel = SLOT_BTN2;
        else if (r_pmask[4])     sel = SLOT_BTN3;
        else                     sel = SLOT_BTN4;
    end

    always_comb begin
        n_kind  = EV_MOTION;
        n_bnum  = '0;
        n_bdown = 1'b0;
        n_abs   = r_p_abs;
        unique case (sel)
            SLOT_PROX: begin
                n_kind = r_p_prox ? EV_PROX_IN : EV_PROX_OUT;
                n_abs  = 1'b0;
            end
            SLOT_MOTION: begin
                n_kind = EV_MOTION;
            end
            SLOT_BTN1, SLOT_BTN2, SLOT_BTN3, SLOT_BTN4: begin
                n_kind  = EV_BUTTON;
                n_bnum  = sel - SLOT_MOTION;
                n_bdown = r_p_btn[2'(sel - SLOT_BTN1)];
            end
            default: begin
                n_kind = EV_MOTION;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs_mode <= 1'b1;
            r_max_y    <= '1;
            r_core_ptr <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ABS_MODE: r_abs_mode <= i_cfg_wdata[0];
                CFG_MAX_Y:    r_max_y    <= i_cfg_wdata[RAW_W-1:0];
                CFG_CORE_PTR: r_core_ptr <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // byte counter and previous pen state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_z    <= '0;
            r_prev_btn  <= '0;
            r_prev_prox <= 1'b0;
        end else if (s_fire) begin
            if (r_idx == '0) begin
                if (b_in[7]) begin
                    r_idx <= IDX_W'(1);
                end
            end else if (r_idx == LAST_IDX) begin
                r_idx <= '0;
                if (dec_prox) begin
                    r_prev_x   <= dec_x;
                    r_prev_y   <= dec_y;
                    r_prev_z   <= dec_z;
                    r_prev_btn <= dec_btn;
                end
                r_prev_prox <= dec_prox;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    // packet bytes, no reset: each is written before it is read
    always_ff @(posedge i_clk) begin
        if (s_fire && (r_idx != LAST_IDX) && ((r_idx != '0) || b_in[7])) begin
            r_store[r_idx] <= b_in;
        end
    end

    // pending events
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pmask <= '0;
        end else begin
            priority if (pkt_done) begin
                r_pmask <= n_mask;
            end else if (pop) begin
                r_pmask <= rest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pkt_done) begin
            r_p_prox <= dec_prox;
            r_p_abs  <= r_abs_mode;
            r_p_x    <= dec_x;
            r_p_y    <= dec_y;
            r_p_z    <= dec_z;
            r_p_btn  <= dec_btn;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= (r_pmask != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_kind  <= n_kind;
            r_out_x     <= r_p_x;
            r_out_y     <= r_p_y;
            r_out_z     <= r_p_z;
            r_out_bnum  <= n_bnum;
            r_out_bdown <= n_bdown;
            r_out_abs   <= n_abs;
            r_out_last  <= (rest == '0);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {3'b000, r_out_abs, r_out_bdown, r_out_bnum, r_out_z,
                              r_out_y, r_out_x};

    // checks
    `TPED_ASSERT(a_idx_range, r_idx <= LAST_IDX, "byte counter beyond packet length")
    `TPED_ASSERT(a_hold_only_busy, !o_s_axis_tready |-> (r_pmask != '0), "input held while idle")
    `TPED_ASSERT(a_pend_kept, (r_pmask != '0) |=> $stable(r_p_x), "pending packet overwritten")
    `TPED_ASSERT(a_one_per_pop, pop |=> ($countones(r_pmask) == $countones($past(r_pmask)) - 1), "event pop count wrong")

endmodule
